// ===== design/pfba_pkg.sv =====
// Shared types, constants and helpers of the page frame bitmap allocator.
// No dependencies; imported by pfba_bitmap_mem and page_frame_bitmap_allocator.
package pfba_pkg;

    localparam int ADDR_W           = 52;
    localparam int PAGES_W          = 13;
    localparam int PAGE_SHIFT       = 12;
    localparam int PAGES_PER_REGION = 4096;
    localparam int MAX_REGIONS      = 4;
    localparam int RGN_W            = 2;
    localparam int WORD_W           = 64;
    localparam int BIT_IDX_W        = 6;
    localparam int PAGE_IDX_W       = 12;
    localparam int WORD_IDX_W       = PAGE_IDX_W - BIT_IDX_W;
    localparam int MEM_AW           = RGN_W + WORD_IDX_W;
    localparam int MEM_DEPTH        = 1 << MEM_AW;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_REGS         = 2 * MAX_REGIONS;

    // request types
    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_ALLOC   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_REGION = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] phys_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] page_addr;
    } t_rsp;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_mem_wr;

    // saturate a configured page count to the region capacity
    function automatic logic [PAGES_W-1:0] eff_pages(input logic [PAGES_W-1:0] p);
        return (p > PAGES_W'(PAGES_PER_REGION)) ? PAGES_W'(PAGES_PER_REGION) : p;
    endfunction

endpackage

// ===== design/pfba_bitmap_mem.sv =====
// Frame bitmap storage: one read and one write port, registered read data.
// Per-word valid bits make unwritten words read as all free. Uses pfba_pkg.
module pfba_bitmap_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfba_pkg::t_mem_rd           i_rd,
    input  pfba_pkg::t_mem_wr           i_wr,
    output logic [pfba_pkg::WORD_W-1:0] o_rd_data
);
    import pfba_pkg::*;

    logic [WORD_W-1:0]    r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [WORD_W-1:0]    r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    // a word never written holds all pages free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== design/page_frame_bitmap_allocator.sv =====
// Page frame bitmap allocator, first fit over up to four regions. Uses pfba_pkg, pfba_bitmap_mem.
// Reserve/free tests each region in turn and read-modify-writes the word of every region holding the page.
// Allocate: the scan reads one bitmap word per cycle through the single read port of the bitmap
// memory, pausing while it steps to the next region. One word in flight at a time.
// Reset: synchronous, active low; clears region registers, control and bitmap valid bits at once,
// so every page reads free right after reset with no clearing pass.
module page_frame_bitmap_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfba_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pfba_pkg::t_req                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pfba_pkg::t_rsp                 o_out_data
);
    import pfba_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RF_CHK  = 3'd1;  // test one region for reserve/free
    localparam logic [2:0] S_RF_RD   = 3'd2;  // read the word holding the page
    localparam logic [2:0] S_RF_WR   = 3'd3;  // modify the bit, write the word back
    localparam logic [2:0] S_AL_SCAN = 3'd4;  // pipelined first-fit scan
    localparam logic [2:0] S_DONE    = 3'd5;  // hand the result to the output register

    // region configuration
    logic [ADDR_W-1:0]  r_base  [MAX_REGIONS];
    logic [PAGES_W-1:0] r_pages [MAX_REGIONS];
    logic [PAGES_W-1:0] s_eff   [MAX_REGIONS];

    // sequencer state
    logic [2:0]            r_state,   n_state;
    logic [1:0]            r_req;
    logic [ADDR_W-1:0]     r_addr;
    logic [RGN_W-1:0]      r_rgn,     n_rgn;      // region under test / scan cursor region
    logic [WORD_IDX_W:0]   r_a_w,     n_a_w;      // scan cursor word, one extra bit for the end
    logic                  r_cur_end, n_cur_end;
    logic [PAGE_IDX_W-1:0] r_j,       n_j;
    logic                  r_hit,     n_hit;
    logic [1:0]            r_status,  n_status;
    logic                  r_found,   n_found;
    // scan check stage: word whose read is in flight
    logic                  r_p_vld,   n_p_vld;
    logic [RGN_W-1:0]      r_p_rgn,   n_p_rgn;
    logic [WORD_IDX_W-1:0] r_p_w,     n_p_w;
    logic [PAGES_W-1:0]    r_p_n,     n_p_n;
    logic [BIT_IDX_W-1:0]  r_k,       n_k;
    // output register
    logic                  r_out_vld;
    t_rsp                  r_out;

    t_mem_rd           s_rd;
    t_mem_wr           s_wr;
    logic [WORD_W-1:0] s_rd_data;

    logic              s_in_acc;
    logic [RGN_W-1:0]  s_sel_rgn;
    logic [ADDR_W-1:0] s_base;
    logic [PAGES_W-1:0] s_n;
    logic [ADDR_W:0]   s_diff;
    logic              s_rf_hit;
    logic              s_last_rgn;
    logic [PAGES_W-1:0] s_limit;
    logic [WORD_W-1:0] s_masked;
    logic [BIT_IDX_W-1:0] s_free_k;
    logic              s_out_free;
    logic [ADDR_W-1:0] s_page;

    // ---------------------------------------------------------------
    // Configuration: even index writes a base, odd index a page count
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_REGIONS; i++) begin
                r_base[i]  <= '0;
                r_pages[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(CFG_REGS))) begin
            if (i_cfg_idx[0]) begin
                r_pages[i_cfg_idx[RGN_W:1]] <= i_cfg_wdata[PAGES_W-1:0];
            end else begin
                r_base[i_cfg_idx[RGN_W:1]] <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            s_eff[i] = eff_pages(r_pages[i]);
        end
    end

    // ---------------------------------------------------------------
    // Bitmap memory: region r owns words r*64 .. r*64+63
    // ---------------------------------------------------------------
    pfba_bitmap_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (s_rd),
        .i_wr      (s_wr),
        .o_rd_data (s_rd_data)
    );

    // ---------------------------------------------------------------
    // Shared datapath
    // ---------------------------------------------------------------
    assign s_in_acc   = i_in_valid && o_in_ready;
    assign s_out_free = !r_out_vld || i_out_ready;
    assign s_last_rgn = (r_rgn == RGN_W'(MAX_REGIONS - 1));

    // one base read port: scan result region in the scan and done states, else region under test
    assign s_sel_rgn = (r_state == S_DONE || r_state == S_AL_SCAN) ? r_p_rgn : r_rgn;
    assign s_base    = r_base[s_sel_rgn];
    assign s_n       = s_eff[r_rgn];

    // hit test: addr - base without borrow, and page offset below the count
    assign s_diff   = {1'b0, r_addr} - {1'b0, s_base};
    assign s_rf_hit = (s_n != '0) && !s_diff[ADDR_W] &&
                      (s_diff[ADDR_W-1:PAGE_SHIFT] < (ADDR_W-PAGE_SHIFT)'(s_n));

    // scan check: pages past the region end count as used
    assign s_limit = r_p_n - PAGES_W'({r_p_w, {BIT_IDX_W{1'b0}}});
    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            s_masked[k] = s_rd_data[k] || !(PAGES_W'(k) < s_limit);
        end
        s_free_k = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (!s_masked[k]) begin
                s_free_k = BIT_IDX_W'(k);
            end
        end
    end

    assign s_page = s_base +
        ADDR_W'({r_p_w, r_k, {PAGE_SHIFT{1'b0}}});

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_rgn     = r_rgn;
        n_a_w     = r_a_w;
        n_cur_end = r_cur_end;
        n_j       = r_j;
        n_hit     = r_hit;
        n_status  = r_status;
        n_found   = r_found;
        n_p_vld   = r_p_vld;
        n_p_rgn   = r_p_rgn;
        n_p_w     = r_p_w;
        n_p_n     = r_p_n;
        n_k       = r_k;
        s_rd      = '0;
        s_wr      = '0;

        case (r_state)
            S_IDLE: begin
                if (s_in_acc) begin
                    n_rgn     = '0;
                    n_a_w     = '0;
                    n_cur_end = 1'b0;
                    n_hit     = 1'b0;
                    n_found   = 1'b0;
                    n_p_vld   = 1'b0;
                    n_status  = ST_OK;
                    case (i_in_data.req_type)
                        REQ_RESERVE, REQ_FREE: n_state = S_RF_CHK;
                        REQ_ALLOC:             n_state = S_AL_SCAN;
                        default:               n_state = S_DONE;
                    endcase
                end
            end

            S_RF_CHK: begin
                if (s_rf_hit) begin
                    n_j     = s_diff[PAGE_SHIFT+PAGE_IDX_W-1:PAGE_SHIFT];
                    n_hit   = 1'b1;
                    n_state = S_RF_RD;
                end else if (s_last_rgn) begin
                    n_status = r_hit ? ST_OK : ST_NO_REGION;
                    n_state  = S_DONE;
                end else begin
                    n_rgn = r_rgn + 1'b1;
                end
            end

            S_RF_RD: begin
                s_rd.en   = 1'b1;
                s_rd.addr = {r_rgn, r_j[PAGE_IDX_W-1:BIT_IDX_W]};
                n_state   = S_RF_WR;
            end

            S_RF_WR: begin
                s_wr.en   = 1'b1;
                s_wr.addr = {r_rgn, r_j[PAGE_IDX_W-1:BIT_IDX_W]};
                s_wr.data = s_rd_data;
                s_wr.data[r_j[BIT_IDX_W-1:0]] = (r_req == REQ_RESERVE);
                if (s_last_rgn) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_rgn   = r_rgn + 1'b1;
                    n_state = S_RF_CHK;
                end
            end

            S_AL_SCAN: begin
                // issue side: one word read per cycle in region and word order, none while stepping region
                n_p_vld = 1'b0;
                if (!r_cur_end) begin
                    if ((s_n != '0) && (PAGES_W'({r_a_w, {BIT_IDX_W{1'b0}}}) < s_n)) begin
                        s_rd.en   = 1'b1;
                        s_rd.addr = {r_rgn, r_a_w[WORD_IDX_W-1:0]};
                        n_p_vld   = 1'b1;
                        n_p_rgn   = r_rgn;
                        n_p_w     = r_a_w[WORD_IDX_W-1:0];
                        n_p_n     = s_n;
                        n_a_w     = r_a_w + 1'b1;
                    end else if (s_last_rgn) begin
                        n_cur_end = 1'b1;
                    end else begin
                        n_rgn = r_rgn + 1'b1;
                        n_a_w = '0;
                    end
                end
                // check side: first word with a free page wins; drop the read behind it
                if (r_p_vld && (s_masked != '1)) begin
                    s_wr.en   = 1'b1;
                    s_wr.addr = {r_p_rgn, r_p_w};
                    s_wr.data = s_rd_data;
                    s_wr.data[s_free_k] = 1'b1;
                    n_k       = s_free_k;
                    n_found   = 1'b1;
                    n_status  = ST_OK;
                    n_p_vld   = 1'b0;
                    n_p_rgn   = r_p_rgn;
                    n_p_w     = r_p_w;
                    n_state   = S_DONE;
                end else if (!r_p_vld && r_cur_end) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end
            end

            S_DONE: begin
                if (s_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= n_p_vld;
            if (r_state == S_DONE && s_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_req  <= i_in_data.req_type;
            r_addr <= i_in_data.phys_addr;
        end
        r_rgn     <= n_rgn;
        r_a_w     <= n_a_w;
        r_cur_end <= n_cur_end;
        r_j       <= n_j;
        r_hit     <= n_hit;
        r_status  <= n_status;
        r_found   <= n_found;
        r_p_rgn   <= n_p_rgn;
        r_p_w     <= n_p_w;
        r_p_n     <= n_p_n;
        r_k       <= n_k;
        // load the result word; page address only for a successful allocate
        if (r_state == S_DONE && s_out_free) begin
            r_out.status    <= r_status;
            r_out.page_addr <= (r_req == REQ_ALLOC && r_found) ? s_page : '0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accepting a word");

    a_write_in_work_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wr.en |-> (r_state == S_RF_WR || r_state == S_AL_SCAN))
        else $error("bitmap write outside a modify state");

    a_check_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> (r_state == S_AL_SCAN))
        else $error("scan check stage busy outside the scan");

    a_rd_wr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_rd.en && s_wr.en) |-> (s_rd.addr != s_wr.addr))
        else $error("read and write of the same bitmap word in one cycle");

endmodule
